### design/dtq_pkg.sv
`timescale 1ns / 1ps
// dtq_pkg: field widths, command and status codes, FSM states for the deadline timer queue.
// No dependencies; imported by deadline_timer_queue.
package dtq_pkg;

    localparam int CMD_W            = 3;
    localparam int TASK_W           = 8;
    localparam int TIME_W           = 64;
    localparam int DELAY_W          = 32;
    localparam int TPM_W            = 20;
    localparam int STATUS_W         = 2;
    localparam int PROD_W           = DELAY_W + TPM_W;
    localparam int QUEUE_DEPTH_DEF  = 16;
    localparam int TASK_ID_BITS_DEF = 8;

    localparam logic [TPM_W-1:0] TPM_RESET = TPM_W'(1000);

    typedef enum logic [CMD_W-1:0] {
        CMD_TICK       = 3'd0,
        CMD_SCHED_AT   = 3'd1,
        CMD_SCHED_IN   = 3'd2,
        CMD_UNSCHED    = 3'd3,
        CMD_RESCHED_AT = 3'd4,
        CMD_RESCHED_IN = 3'd5
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2,
        ST_QUEUED    = 2'd3
    } status_t;

    typedef enum logic {
        KIND_ACK  = 1'b0,
        KIND_FIRE = 1'b1
    } kind_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ADD,
        S_SCAN,
        S_DECIDE,
        S_SHIFT,
        S_PUT,
        S_RESP,
        S_TICK_RD,
        S_TICK_CHK,
        S_TICK_END
    } state_t;

endpackage

### design/deadline_timer_queue.sv
`timescale 1ns / 1ps
// deadline_timer_queue: deadline-sorted task queue in a circular slot memory, plus time counter.
// Depends on dtq_pkg.
//
//  channel | ports                                            | direction
//  --------+--------------------------------------------------+----------
//  request | s_valid s_ready s_command s_task_id s_deadline   | in
//          | s_delay_ms                                       |
//  result  | m_valid m_ready m_kind m_out_task m_status m_last | out
//  config  | cfg_wr_en cfg_wr_data (ticks_per_ms)             | in
//
// Commands scan N queued tasks (the relative forms first add the delay to the time): one
// slot read per cycle to scan, then one slot move per cycle through the single read port.
// Tick reads the head slot and fires it while due, sending the last fire at the end.
// Firing the head on a tick only advances a pointer.
// Reset is synchronous and needs no clearing pass; slot contents stay undefined until written.
// Results wait in an output register; the sequencer stalls only when a second result is due.
module deadline_timer_queue #(
    parameter int QUEUE_DEPTH  = dtq_pkg::QUEUE_DEPTH_DEF,
    parameter int TASK_ID_BITS = dtq_pkg::TASK_ID_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [dtq_pkg::CMD_W-1:0]     s_command,
    input  logic [dtq_pkg::TASK_W-1:0]    s_task_id,
    input  logic [dtq_pkg::TIME_W-1:0]    s_deadline,
    input  logic [dtq_pkg::DELAY_W-1:0]   s_delay_ms,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic                          m_kind,
    output logic [dtq_pkg::TASK_W-1:0]    m_out_task,
    output logic [dtq_pkg::STATUS_W-1:0]  m_status,
    output logic                          m_last,
    input  logic                          cfg_wr_en,
    input  logic [dtq_pkg::TPM_W-1:0]     cfg_wr_data
);
    import dtq_pkg::*;

    localparam int AddrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CntW  = $clog2(QUEUE_DEPTH + 1);
    localparam int SumW  = CntW + 1;
    localparam logic [CntW-1:0] DepthC = CntW'(QUEUE_DEPTH);
    localparam logic [CntW-1:0] OneC   = CntW'(1);

    typedef struct packed {
        logic [TIME_W-1:0]       deadline;
        logic [TASK_ID_BITS-1:0] id;
    } entry_t;

    // logical queue position -> slot address
    function automatic logic [AddrW-1:0] phys(input logic [AddrW-1:0] head,
                                               input logic [CntW-1:0] idx);
        logic [SumW-1:0] sum;
        sum = SumW'(head) + SumW'(idx);
        if (sum >= SumW'(QUEUE_DEPTH)) begin
            sum = sum - SumW'(QUEUE_DEPTH);
        end
        return AddrW'(sum);
    endfunction

    entry_t             mem [QUEUE_DEPTH];
    entry_t             rdata_reg;
    logic               mem_re;
    logic [AddrW-1:0]   mem_raddr;
    logic               mem_we;
    logic [AddrW-1:0]   mem_waddr;
    entry_t             mem_wdata;

    state_t                  state_reg, state_next;
    logic                    out_valid_reg, out_valid_next;
    logic [CntW-1:0]         count_reg, count_next;
    logic [AddrW-1:0]        head_reg, head_next;
    logic [TIME_W-1:0]       time_reg, time_next;
    logic [TPM_W-1:0]        tpm_reg, tpm_next;
    logic                    pend_reg, pend_next;
    logic                    fire_pend_reg, fire_pend_next;

    cmd_t                    cmd_reg, cmd_next;
    logic [TASK_ID_BITS-1:0] id_reg, id_next;
    logic [TIME_W-1:0]       when_reg, when_next;
    logic [PROD_W-1:0]       prod_reg, prod_next;
    logic [CntW-1:0]         scan_idx_reg, scan_idx_next;
    logic [CntW-1:0]         rd_idx_reg, rd_idx_next;
    logic                    found_reg, found_next;
    logic [CntW-1:0]         match_reg, match_next;
    logic [CntW-1:0]         ins_reg, ins_next;
    status_t                 status_reg, status_next;
    logic                    up_reg, up_next;
    logic                    put_reg, put_next;
    logic [CntW-1:0]         src_reg, src_next;
    logic [CntW-1:0]         dst_reg, dst_next;
    logic [CntW-1:0]         left_reg, left_next;
    logic [CntW-1:0]         newcnt_reg, newcnt_next;
    logic [TASK_ID_BITS-1:0] fire_task_reg, fire_task_next;
    kind_t                   out_kind_reg, out_kind_next;
    logic [TASK_W-1:0]       out_task_reg, out_task_next;
    status_t                 out_status_reg, out_status_next;
    logic                    out_last_reg, out_last_next;

    logic                    out_free;
    logic                    emit;
    kind_t                   emit_kind;
    logic [TASK_ID_BITS-1:0] emit_task;
    status_t                 emit_status;
    logic                    emit_last;
    logic                    is_sched;

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_re) begin
            rdata_reg <= mem[mem_raddr];
        end
    end

    assign s_ready    = (state_reg == S_IDLE);
    assign m_valid    = out_valid_reg;
    assign m_kind     = out_kind_reg;
    assign m_out_task = out_task_reg;
    assign m_status   = out_status_reg;
    assign m_last     = out_last_reg;
    assign out_free   = !out_valid_reg || m_ready;
    assign is_sched   = (cmd_reg == CMD_SCHED_AT) || (cmd_reg == CMD_SCHED_IN);

    always_comb begin
        state_next      = state_reg;
        count_next      = count_reg;
        head_next       = head_reg;
        time_next       = time_reg;
        tpm_next        = cfg_wr_en ? cfg_wr_data : tpm_reg;
        pend_next       = pend_reg;
        fire_pend_next  = fire_pend_reg;
        cmd_next        = cmd_reg;
        id_next         = id_reg;
        when_next       = when_reg;
        prod_next       = prod_reg;
        scan_idx_next   = scan_idx_reg;
        rd_idx_next     = rd_idx_reg;
        found_next      = found_reg;
        match_next      = match_reg;
        ins_next        = ins_reg;
        status_next     = status_reg;
        up_next         = up_reg;
        put_next        = put_reg;
        src_next        = src_reg;
        dst_next        = dst_reg;
        left_next       = left_reg;
        newcnt_next     = newcnt_reg;
        fire_task_next  = fire_task_reg;
        mem_re          = 1'b0;
        mem_raddr       = head_reg;
        mem_we          = 1'b0;
        mem_waddr       = head_reg;
        mem_wdata       = rdata_reg;
        emit            = 1'b0;
        emit_kind       = KIND_ACK;
        emit_task       = id_reg;
        emit_status     = ST_OK;
        emit_last       = 1'b1;

        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd_next      = cmd_t'(s_command);
                    id_next       = TASK_ID_BITS'(s_task_id);
                    when_next     = s_deadline;
                    prod_next     = PROD_W'(s_delay_ms) * PROD_W'(tpm_reg);
                    scan_idx_next = '0;
                    found_next    = 1'b0;
                    match_next    = '0;
                    ins_next      = '0;
                    pend_next     = 1'b0;
                    unique case (cmd_t'(s_command)) inside
                        CMD_TICK: begin
                            time_next      = time_reg + TIME_W'(1);
                            fire_pend_next = 1'b0;
                            state_next     = S_TICK_RD;
                        end
                        CMD_SCHED_AT, CMD_UNSCHED, CMD_RESCHED_AT: begin
                            state_next = S_SCAN;
                        end
                        CMD_SCHED_IN, CMD_RESCHED_IN: begin
                            state_next = S_ADD;
                        end
                        default: begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end

            S_ADD: begin
                when_next  = time_reg + TIME_W'(prod_reg);
                state_next = S_SCAN;
            end

            S_SCAN: begin
                if (pend_reg) begin
                    if (!found_reg && (rdata_reg.id == id_reg)) begin
                        found_next = 1'b1;
                        match_next = rd_idx_reg;
                    end else if (rdata_reg.deadline <= when_reg) begin
                        ins_next = ins_reg + OneC;
                    end
                end
                if (scan_idx_reg < count_reg) begin
                    mem_re        = 1'b1;
                    mem_raddr     = phys(head_reg, scan_idx_reg);
                    rd_idx_next   = scan_idx_reg;
                    scan_idx_next = scan_idx_reg + OneC;
                    pend_next     = 1'b1;
                end else begin
                    pend_next = 1'b0;
                    if (!pend_reg) begin
                        state_next = S_DECIDE;
                    end
                end
            end

            S_DECIDE: begin
                status_next = ST_OK;
                put_next    = 1'b0;
                up_next     = 1'b1;
                src_next    = count_reg - OneC;
                left_next   = '0;
                newcnt_next = count_reg;
                pend_next   = 1'b0;
                state_next  = S_SHIFT;
                if (is_sched && found_reg) begin
                    status_next = ST_QUEUED;
                    state_next  = S_RESP;
                end else if (cmd_reg == CMD_UNSCHED) begin
                    if (found_reg) begin
                        up_next     = 1'b0;
                        src_next    = match_reg + OneC;
                        left_next   = count_reg - match_reg - OneC;
                        newcnt_next = count_reg - OneC;
                    end else begin
                        status_next = ST_NOT_FOUND;
                        state_next  = S_RESP;
                    end
                end else if (found_reg) begin
                    // move in place: close the old slot, open the new one
                    put_next = 1'b1;
                    if (ins_reg > match_reg) begin
                        up_next   = 1'b0;
                        src_next  = match_reg + OneC;
                        left_next = ins_reg - match_reg;
                    end else begin
                        up_next   = 1'b1;
                        src_next  = match_reg - OneC;
                        left_next = match_reg - ins_reg;
                    end
                end else if (count_reg == DepthC) begin
                    status_next = ST_FULL;
                    state_next  = S_RESP;
                end else begin
                    put_next    = 1'b1;
                    up_next     = 1'b1;
                    src_next    = count_reg - OneC;
                    left_next   = count_reg - ins_reg;
                    newcnt_next = count_reg + OneC;
                end
            end

            S_SHIFT: begin
                if (pend_reg) begin
                    mem_we    = 1'b1;
                    mem_waddr = phys(head_reg, dst_reg);
                    mem_wdata = rdata_reg;
                end
                if (left_reg != '0) begin
                    mem_re    = 1'b1;
                    mem_raddr = phys(head_reg, src_reg);
                    dst_next  = up_reg ? (src_reg + OneC) : (src_reg - OneC);
                    src_next  = up_reg ? (src_reg - OneC) : (src_reg + OneC);
                    left_next = left_reg - OneC;
                    pend_next = 1'b1;
                end else begin
                    pend_next = 1'b0;
                    if (!pend_reg) begin
                        count_next = newcnt_reg;
                        state_next = put_reg ? S_PUT : S_RESP;
                    end
                end
            end

            S_PUT: begin
                mem_we     = 1'b1;
                mem_waddr  = phys(head_reg, ins_reg);
                mem_wdata  = '{deadline: when_reg, id: id_reg};
                state_next = S_RESP;
            end

            S_RESP: begin
                if (out_free) begin
                    emit        = 1'b1;
                    emit_status = status_reg;
                    state_next  = S_IDLE;
                end
            end

            S_TICK_RD: begin
                if (count_reg == '0) begin
                    state_next = S_TICK_END;
                end else begin
                    mem_re     = 1'b1;
                    mem_raddr  = head_reg;
                    state_next = S_TICK_CHK;
                end
            end

            S_TICK_CHK: begin
                if (rdata_reg.deadline <= time_reg) begin
                    if (!fire_pend_reg || out_free) begin
                        // previous fired task is not the last one
                        if (fire_pend_reg) begin
                            emit      = 1'b1;
                            emit_kind = KIND_FIRE;
                            emit_task = fire_task_reg;
                            emit_last = 1'b0;
                        end
                        fire_pend_next = 1'b1;
                        fire_task_next = rdata_reg.id;
                        head_next      = phys(head_reg, OneC);
                        count_next     = count_reg - OneC;
                        state_next     = S_TICK_RD;
                    end
                end else begin
                    state_next = S_TICK_END;
                end
            end

            S_TICK_END: begin
                if (!fire_pend_reg) begin
                    state_next = S_IDLE;
                end else if (out_free) begin
                    emit           = 1'b1;
                    emit_kind      = KIND_FIRE;
                    emit_task      = fire_task_reg;
                    emit_last      = 1'b1;
                    fire_pend_next = 1'b0;
                    state_next     = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase

        out_valid_next  = out_valid_reg;
        out_kind_next   = out_kind_reg;
        out_task_next   = out_task_reg;
        out_status_next = out_status_reg;
        out_last_next   = out_last_reg;
        if (emit) begin
            out_valid_next  = 1'b1;
            out_kind_next   = emit_kind;
            out_task_next   = TASK_W'(emit_task);
            out_status_next = emit_status;
            out_last_next   = emit_last;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            count_reg     <= '0;
            head_reg      <= '0;
            time_reg      <= '0;
            tpm_reg       <= TPM_RESET;
            pend_reg      <= 1'b0;
            fire_pend_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            count_reg     <= count_next;
            head_reg      <= head_next;
            time_reg      <= time_next;
            tpm_reg       <= tpm_next;
            pend_reg      <= pend_next;
            fire_pend_reg <= fire_pend_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg        <= cmd_next;
        id_reg         <= id_next;
        when_reg       <= when_next;
        prod_reg       <= prod_next;
        scan_idx_reg   <= scan_idx_next;
        rd_idx_reg     <= rd_idx_next;
        found_reg      <= found_next;
        match_reg      <= match_next;
        ins_reg        <= ins_next;
        status_reg     <= status_next;
        up_reg         <= up_next;
        put_reg        <= put_next;
        src_reg        <= src_next;
        dst_reg        <= dst_next;
        left_reg       <= left_next;
        newcnt_reg     <= newcnt_next;
        fire_task_reg  <= fire_task_next;
        out_kind_reg   <= out_kind_next;
        out_task_reg   <= out_task_next;
        out_status_reg <= out_status_next;
        out_last_reg   <= out_last_next;
    end

endmodule
